/* rtl/core/ohlcv_bar_aggregator_top_assert.svh */
// Assertion macros for the OHLCV bar aggregator checker.
// Used by ohlcv_bar_aggregator_top_chk only.
`ifndef OHLCV_BAR_AGGREGATOR_TOP_ASSERT_SVH
`define OHLCV_BAR_AGGREGATOR_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define OBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/oba_pkg.sv */
// Package for the OHLCV bar aggregator: constants, types, helper functions.
// No dependencies.
`default_nettype none
package oba_pkg;
  localparam int unsigned SYMBOLS    = 64;
  localparam int unsigned TIMEFRAMES = 5;
  localparam int unsigned SLOTS      = SYMBOLS * TIMEFRAMES;
  localparam int unsigned SYM_W      = 6;
  localparam int unsigned TF_W       = 3;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned TS_W       = 48;
  localparam int unsigned VOL_W      = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned FILL_W     = 6;
  localparam int unsigned FILL_LIMIT = 62;
  localparam int unsigned MASK_W     = 5;
  // slot word: start, open, high, low, close, volume, count, last close, history
  localparam int unsigned SLOT_DW    = 6 * TS_W + VOL_W + CNT_W + 1;
  localparam int unsigned IN_DATA_W  = 200;
  localparam int unsigned OUT_DATA_W = 352;

  localparam logic OP_TRADE = 1'b0;
  localparam logic OP_TICK  = 1'b1;
  localparam logic EV_UPDATE = 1'b0;
  localparam logic EV_CLOSE  = 1'b1;
  localparam logic CFG_MASK = 1'b0;
  localparam logic CFG_FILL = 1'b1;

  typedef struct packed {
    logic [TS_W-1:0]  start;
    logic [TS_W-1:0]  open_p;
    logic [TS_W-1:0]  high_p;
    logic [TS_W-1:0]  low_p;
    logic [TS_W-1:0]  close_p;
    logic [VOL_W-1:0] vol;
    logic [CNT_W-1:0] cnt;
    logic [TS_W-1:0]  last_p;
    logic             hist;
  } slot_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_NEXT_TF, ST_RD, ST_DIV, ST_DECIDE,
    ST_EMIT_CLOSE, ST_EMIT_OPEN, ST_FILL, ST_WRITE
  } state_t;

  // bar length in ms per timeframe
  function automatic logic [26:0] tf_len(input logic [TF_W-1:0] tf);
    case (tf)
      3'd0: tf_len = 27'd1000;
      3'd1: tf_len = 27'd60000;
      3'd2: tf_len = 27'd300000;
      3'd3: tf_len = 27'd3600000;
      default: tf_len = 27'd86400000;
    endcase
  endfunction
endpackage
`default_nettype wire

/* rtl/core/ohlcv_bar_aggregator_top.sv */
// OHLCV bar aggregator top level. Uses oba_pkg and oba_ram.
// A trade visits each enabled timeframe in turn (read, 48-step serial divider
// aligns the timestamp, decide, emit, write-back); a tick works on its own timeframe
// only, with a fill step for carried-forward empty bars. One word in flight at a time.
// Reset (rst_n low, synchronous) clears control state, then a clearing pass
// over all 320 slots zeroes the slot memory before the input is ready.
`default_nettype none
module ohlcv_bar_aggregator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: operation, symbol_index, timeframe_index, timestamp_ms, price, trade_size
  input  wire logic [oba_pkg::IN_DATA_W-1:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: event_kind, out_symbol, out_timeframe, bar_start, open_price,
  // high_price, low_price, close_price, volume, trade_count
  output logic [oba_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic             out_tlast,   // last_of_run
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);
  import oba_pkg::*;

  state_t state_r, state_nxt;
  logic [MASK_W-1:0] mask_r;
  logic [FILL_W-1:0] fill_r;
  logic [SLOT_W-1:0] clr_r, clr_nxt;

  // latched input
  logic              op_r, op_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [TF_W-1:0]   tf_r, tf_nxt;
  logic [TS_W-1:0]   ts_r, ts_nxt, price_r, price_nxt, size_r, size_nxt;
  logic              any_r, any_nxt;

  // working slot and divider
  slot_t             sl_r, sl_nxt;
  logic [TS_W-1:0]   quo_r, quo_nxt;
  logic [27:0]       rem_r, rem_nxt;
  logic [5:0]        bit_r, bit_nxt;
  logic [TS_W-1:0]   cur_r, cur_nxt;     // aligned start
  logic [TS_W-1:0]   nxt_r, nxt_nxt;     // fill bar start
  logic [TS_W-1:0]   lastp_r, lastp_nxt;
  logic [FILL_W-1:0] filled_r, filled_nxt;
  logic              close_pend_r, close_pend_nxt;

  // output word
  logic              ov_r, ov_nxt, ol_r, ol_nxt;
  logic [OUT_DATA_W-1:0] od_r, od_nxt;

  // slot memory
  logic              we;
  logic [SLOT_W-1:0] waddr, raddr;
  slot_t             wdata, rdata;
  logic [SLOT_DW-1:0] rraw;

  oba_ram #(.WIDTH(SLOT_DW), .DEPTH(SLOTS)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rraw)
  );
  assign rdata = slot_t'(rraw);

  logic [SLOT_W-1:0] slot_idx;
  assign slot_idx = SLOT_W'(sym_r * TIMEFRAMES) + SLOT_W'(tf_r);

  logic [26:0] len;
  assign len = tf_len(tf_r);

  logic [FILL_W-1:0] cap;
  assign cap = (fill_r > FILL_W'(FILL_LIMIT)) ? FILL_W'(FILL_LIMIT) : fill_r;

  // volume-sum and divider-step operands
  logic [VOL_W:0]   vsum;
  assign vsum = {1'b0, sl_r.vol} + {17'd0, size_r};
  logic [27:0]      rtry;
  assign rtry = {rem_r[26:0], ts_r[bit_r]};

  function automatic logic [OUT_DATA_W-1:0] pack_out(
    input logic kind, input logic [SYM_W-1:0] s, input logic [TF_W-1:0] t,
    input logic [TS_W-1:0] st, input logic [TS_W-1:0] o, input logic [TS_W-1:0] h,
    input logic [TS_W-1:0] l, input logic [TS_W-1:0] c, input logic [VOL_W-1:0] v,
    input logic [CNT_W-1:0] n);
    pack_out = {6'd0, n, v, c, l, h, o, st, t, s, kind};
  endfunction

  assign in_tready  = (state_r == ST_IDLE) && !ov_r;
  assign cfg_ready  = (state_r == ST_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      mask_r  <= MASK_W'(15);
      fill_r  <= FILL_W'(62);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MASK) mask_r <= cfg_data[MASK_W-1:0];
        else                       fill_r <= cfg_data;
      end
    end
    op_r <= op_nxt; sym_r <= sym_nxt; tf_r <= tf_nxt; ts_r <= ts_nxt;
    price_r <= price_nxt; size_r <= size_nxt; any_r <= any_nxt;
    sl_r <= sl_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt; bit_r <= bit_nxt;
    cur_r <= cur_nxt; nxt_r <= nxt_nxt; lastp_r <= lastp_nxt;
    filled_r <= filled_nxt; close_pend_r <= close_pend_nxt;
    ol_r <= ol_nxt; od_r <= od_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r;
    op_nxt = op_r; sym_nxt = sym_r; tf_nxt = tf_r; ts_nxt = ts_r;
    price_nxt = price_r; size_nxt = size_r; any_nxt = any_r;
    sl_nxt = sl_r; quo_nxt = quo_r; rem_nxt = rem_r; bit_nxt = bit_r;
    cur_nxt = cur_r; nxt_nxt = nxt_r; lastp_nxt = lastp_r;
    filled_nxt = filled_r; close_pend_nxt = close_pend_r;
    ov_nxt = ov_r && !out_tready; ol_nxt = ol_r; od_nxt = od_r;
    we = 1'b0; waddr = slot_idx; wdata = sl_r; raddr = slot_idx;
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_r; wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SLOT_W'(SLOTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt    = in_tdata[0];
          sym_nxt   = in_tdata[6:1];
          tf_nxt    = (in_tdata[0] == OP_TRADE) ? '0 : in_tdata[9:7];
          ts_nxt    = in_tdata[57:10];
          price_nxt = in_tdata[105:58];
          size_nxt  = in_tdata[153:106];
          any_nxt   = 1'b0;
          state_nxt = ST_NEXT_TF;
        end
      end
      ST_NEXT_TF: begin
        // pick the timeframe to work on, or finish
        if (op_r == OP_TICK) begin
          if (tf_r < TF_W'(TIMEFRAMES) && mask_r[tf_r]) state_nxt = ST_RD;
          else state_nxt = ST_IDLE;
        end else if (tf_r >= TF_W'(TIMEFRAMES)) begin
          state_nxt = ST_IDLE;
        end else if (mask_r[tf_r]) begin
          state_nxt = ST_RD;
        end else begin
          tf_nxt = tf_r + 1'b1;
        end
        rem_nxt = '0; quo_nxt = '0; bit_nxt = 6'(TS_W - 1);
      end
      ST_RD: begin
        // memory read issued; start division
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one restoring-division step per cycle
        if (bit_r == 6'(TS_W - 1)) sl_nxt = rdata;
        if (rtry >= {1'b0, len}) begin
          rem_nxt = rtry - {1'b0, len};
          quo_nxt = {quo_r[TS_W-2:0], 1'b1};
        end else begin
          rem_nxt = rtry;
          quo_nxt = {quo_r[TS_W-2:0], 1'b0};
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cur_nxt = ts_r - TS_W'(rem_r);
        close_pend_nxt = 1'b0;
        if (op_r == OP_TRADE) begin
          if (sl_r.cnt != '0 && cur_nxt > sl_r.start) begin
            close_pend_nxt = 1'b1;
            state_nxt = ST_EMIT_CLOSE;
          end else begin
            if (sl_r.cnt == '0) begin
              sl_nxt.start = cur_nxt; sl_nxt.open_p = price_r; sl_nxt.high_p = price_r;
              sl_nxt.low_p = price_r; sl_nxt.close_p = price_r;
              sl_nxt.vol = {16'd0, size_r}; sl_nxt.cnt = 32'd1;
            end else begin
              if (price_r > sl_r.high_p) sl_nxt.high_p = price_r;
              if (price_r < sl_r.low_p) sl_nxt.low_p = price_r;
              sl_nxt.close_p = price_r;
              sl_nxt.vol = vsum[VOL_W] ? '1 : vsum[VOL_W-1:0];
              if (sl_r.cnt != '1) sl_nxt.cnt = sl_r.cnt + 1'b1;
            end
            state_nxt = ST_EMIT_OPEN;
          end
        end else begin
          if (sl_r.cnt != '0) lastp_nxt = sl_r.close_p;
          else lastp_nxt = sl_r.last_p;
          if (sl_r.cnt == '0 && !sl_r.hist) begin
            state_nxt = ST_IDLE;
          end else if (sl_r.start == '0) begin
            sl_nxt.start = cur_nxt; sl_nxt.open_p = lastp_nxt; sl_nxt.high_p = lastp_nxt;
            sl_nxt.low_p = lastp_nxt; sl_nxt.close_p = lastp_nxt;
            sl_nxt.vol = '0; sl_nxt.cnt = '0;
            state_nxt = ST_EMIT_OPEN;
          end else if (cur_nxt <= sl_r.start) begin
            state_nxt = ST_IDLE;
          end else begin
            close_pend_nxt = 1'b1;
            state_nxt = ST_EMIT_CLOSE;
          end
        end
      end
      ST_EMIT_CLOSE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; ol_nxt = 1'b0;
          od_nxt = pack_out(EV_CLOSE, sym_r, tf_r, sl_r.start, sl_r.open_p, sl_r.high_p,
                            sl_r.low_p, sl_r.close_p, sl_r.vol, sl_r.cnt);
          sl_nxt.last_p = sl_r.close_p; sl_nxt.hist = 1'b1;
          nxt_nxt = sl_r.start + TS_W'(len);
          filled_nxt = '0;
          if (op_r == OP_TRADE) begin
            sl_nxt.start = cur_r; sl_nxt.open_p = price_r; sl_nxt.high_p = price_r;
            sl_nxt.low_p = price_r; sl_nxt.close_p = price_r;
            sl_nxt.vol = {16'd0, size_r}; sl_nxt.cnt = 32'd1;
            state_nxt = ST_EMIT_OPEN;
          end else begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        // carried-forward empty bars, one per cycle while the output is not stalled
        if (nxt_r < cur_r && filled_r < cap) begin
          if (!ov_r || out_tready) begin
            ov_nxt = 1'b1; ol_nxt = 1'b0;
            od_nxt = pack_out(EV_CLOSE, sym_r, tf_r, nxt_r, lastp_r, lastp_r, lastp_r,
                              lastp_r, '0, '0);
            sl_nxt.last_p = lastp_r;
            nxt_nxt = nxt_r + TS_W'(len);
            filled_nxt = filled_r + 1'b1;
          end
        end else begin
          sl_nxt.start = cur_r; sl_nxt.open_p = lastp_r; sl_nxt.high_p = lastp_r;
          sl_nxt.low_p = lastp_r; sl_nxt.close_p = lastp_r;
          sl_nxt.vol = '0; sl_nxt.cnt = '0;
          state_nxt = ST_EMIT_OPEN;
        end
      end
      ST_EMIT_OPEN: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = pack_out(EV_UPDATE, sym_r, tf_r, sl_r.start, sl_r.open_p, sl_r.high_p,
                            sl_r.low_p, sl_r.close_p, sl_r.vol, sl_r.cnt);
          // last word of a tick always; of a trade when no later timeframe is enabled
          if (op_r == OP_TICK) ol_nxt = 1'b1;
          else ol_nxt = ((mask_r >> (tf_r + 1'b1)) == '0) || (tf_r == TF_W'(TIMEFRAMES - 1));
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        we = 1'b1;
        tf_nxt = tf_r + 1'b1;
        state_nxt = (op_r == OP_TICK) ? ST_IDLE : ST_NEXT_TF;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/core/oba_ram.sv */
// Generic single-port-write, registered-read RAM.
// No dependencies.
`default_nettype none
module oba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/ohlcv_bar_aggregator_top_chk.sv */
// Port-level checker for the OHLCV bar aggregator, bound to the top level.
// Depends on ohlcv_bar_aggregator_top_assert.svh.
`default_nettype none
`include "ohlcv_bar_aggregator_top_assert.svh"
module ohlcv_bar_aggregator_top_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [351:0] out_tdata,
  input wire logic         out_tlast,
  input wire logic         cfg_ready
);
  `OBA_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `OBA_ASSERT_IMP(a_busy_out, clk, rst_n, out_tvalid, !in_tready)
  `OBA_ASSERT_NXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `OBA_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_ready, in_tready)
endmodule

bind ohlcv_bar_aggregator_top ohlcv_bar_aggregator_top_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast), .cfg_ready(cfg_ready)
);
`default_nettype wire
